### hw/rtl/limit_order_book_matcher_unit_defines.svh
// Assertion macros for the order book matcher.
// Used by the top level only; no other dependencies.
`ifndef LIMIT_ORDER_BOOK_MATCHER_UNIT_DEFINES_SVH
`define LIMIT_ORDER_BOOK_MATCHER_UNIT_DEFINES_SVH
// Assert a property on clk with reset disabling.
`define LOBM_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Assert a property on clk that also holds during reset.
`define LOBM_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);
`endif

### hw/rtl/lobm_pkg.sv
// Package for the order book matcher: sizes, action and status codes, slot type.
// No dependencies.
package lobm_pkg;
  localparam int SLOTS = 256;
  localparam int IDX_W = $clog2(SLOTS);
  localparam int PRICE_W = 32;
  localparam int QTY_W = 32;
  localparam int TOT_W = 40;
  localparam int OUTP_W = 33;

  localparam logic [1:0] ACT_ADD = 2'd0;
  localparam logic [1:0] ACT_CANCEL = 2'd1;
  localparam logic [1:0] ACT_EXEC = 2'd2;
  localparam logic [1:0] ACT_NONE = 2'd3;

  localparam logic [1:0] ST_DONE = 2'd0;
  localparam logic [1:0] ST_NOTFOUND = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  typedef struct packed {
    logic               side;
    logic [PRICE_W-1:0] price;
    logic [QTY_W-1:0]   qty;
    logic [31:0]        ident;
    logic [31:0]        arrival;
  } slot_t;

  localparam int SLOT_W = $bits(slot_t);
endpackage

### hw/rtl/lobm_ram.sv
// Generic single-port-write, single-read RAM with registered read data.
// No dependencies.
module lobm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

### hw/rtl/limit_order_book_matcher_unit.sv
// Order book matcher, top level: sequencer scanning the slot table memory.
// Depends on lobm_pkg, lobm_ram and limit_order_book_matcher_unit_defines.svh.
//
// One item at a time: in_tready is high only while the block is idle. Every table pass reads
// the 256-entry slot memory one slot a cycle. A cancel or execute runs an id search pass, a
// write step and the summary pass before in_tready returns; an add runs the same plus a
// further search pass and write step for each resting order it fills, and the unused action
// runs only the summary pass. The slot memory has a single read port. Valid bits live in
// flip-flops; the result waits in an output register, and the block holds in its last state
// while that register is still full.
module limit_order_book_matcher_unit (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // [1:0] action
  input  logic [1:0]   in_tuser,
  // [31:0] ident, [32] side, [64:33] price, [96:65] quantity
  input  logic [103:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // [32:0] best_bid_price, [72:33] best_bid_total, [105:73] best_ask_price,
  // [145:106] best_ask_total, [177:146] matched_amount, [179:178] status
  output logic [183:0] out_tdata
);
  import lobm_pkg::*;
  `include "limit_order_book_matcher_unit_defines.svh"

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SCAN = 3'd1;
  localparam logic [2:0] S_FILL = 3'd2;
  localparam logic [2:0] S_SUM  = 3'd3;
  localparam logic [2:0] S_OUT  = 3'd4;

  logic [2:0] state_r, state_nxt;
  logic [SLOTS-1:0] valid_r;
  logic [31:0] arr_r;
  logic [IDX_W:0] cnt_r;
  logic        rd_v_r;
  logic [IDX_W-1:0] rd_i_r;

  logic [1:0] act_r;
  logic [31:0] id_r;
  logic side_r;
  logic [PRICE_W-1:0] price_r;
  logic [QTY_W-1:0] qty_r;
  logic [31:0] stamp_r;
  logic [31:0] matched_r;
  logic [1:0] status_r;

  logic found_r;
  logic [IDX_W-1:0] fidx_r;
  slot_t fslot_r;

  logic bf_r, af_r;
  logic [PRICE_W-1:0] bp_r, ap_r;
  logic [TOT_W-1:0] bt_r, at_r;
  logic [183:0] out_r;
  logic out_v_r;

  logic we;
  logic [IDX_W-1:0] waddr, raddr;
  slot_t wslot, rslot;
  logic [SLOT_W-1:0] rword;

  lobm_ram #(.WIDTH(SLOT_W), .DEPTH(SLOTS)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wslot), .raddr(raddr), .rdata(rword)
  );
  assign rslot = slot_t'(rword);
  assign raddr = cnt_r[IDX_W-1:0];

  // free slot: lowest invalid
  logic have_free;
  logic [IDX_W-1:0] free_idx;
  always_comb begin
    have_free = 1'b0;
    free_idx = '0;
    for (int i = SLOTS-1; i >= 0; i--) begin
      if (!valid_r[i]) begin
        have_free = 1'b1;
        free_idx = IDX_W'(i);
      end
    end
  end

  logic [31:0] age_c, age_f;
  assign age_c = arr_r - rslot.arrival;
  assign age_f = arr_r - fslot_r.arrival;

  logic cand, better;
  always_comb begin
    cand = rd_v_r && valid_r[rd_i_r];
    better = 1'b0;
    if (act_r == ACT_ADD) begin
      cand = cand && (rslot.side != side_r);
      if (!found_r) better = 1'b1;
      else if (rslot.price != fslot_r.price)
        better = side_r ? (rslot.price > fslot_r.price) : (rslot.price < fslot_r.price);
      else better = age_c > age_f;
    end else begin
      cand = cand && (rslot.ident == id_r);
      better = !found_r || (age_c < age_f);
    end
  end

  logic crosses;
  assign crosses = side_r ? (price_r <= fslot_r.price) : (price_r >= fslot_r.price);
  logic [QTY_W-1:0] fill;
  assign fill = (qty_r < fslot_r.qty) ? qty_r : fslot_r.qty;
  logic kill;
  assign kill = (act_r == ACT_CANCEL && qty_r == {QTY_W{1'b1}}) || (qty_r >= fslot_r.qty);

  logic [TOT_W-1:0] addq_c;
  logic [TOT_W:0] sum_b, sum_a;
  assign addq_c = TOT_W'(rslot.qty);
  assign sum_b = {1'b0, bt_r} + {1'b0, addq_c};
  assign sum_a = {1'b0, at_r} + {1'b0, addq_c};

  always_comb begin
    we = 1'b0;
    waddr = fidx_r;
    wslot = fslot_r;
    if (state_r == S_FILL && act_r == ACT_ADD && found_r && crosses && qty_r != '0) begin
      we = 1'b1;
      wslot.qty = fslot_r.qty - fill;
    end else if (state_r == S_FILL && act_r != ACT_ADD && found_r) begin
      we = !kill;
      wslot.qty = fslot_r.qty - qty_r;
    end else if (state_r == S_FILL && act_r == ACT_ADD && qty_r != '0 && have_free) begin
      we = 1'b1;
      waddr = free_idx;
      wslot.side = side_r;
      wslot.price = price_r;
      wslot.qty = qty_r;
      wslot.ident = id_r;
      wslot.arrival = stamp_r;
    end
  end

  assign in_tready = (state_r == S_IDLE);
  assign out_tvalid = out_v_r;
  assign out_tdata = out_r;
  logic scan_end;
  assign scan_end = rd_v_r && (rd_i_r == IDX_W'(SLOTS-1));

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (in_tvalid) state_nxt = (in_tuser == ACT_NONE) ? S_SUM : S_SCAN;
      S_SCAN: if (scan_end) state_nxt = S_FILL;
      S_FILL: begin
        if (act_r == ACT_ADD && found_r && crosses && qty_r != '0) state_nxt = S_SCAN;
        else state_nxt = S_SUM;
      end
      S_SUM: if (scan_end) state_nxt = S_OUT;
      S_OUT: if (!out_v_r || out_tready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      valid_r <= '0;
      arr_r <= '0;
      cnt_r <= '0;
      rd_v_r <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_OUT && (!out_v_r || out_tready)) begin
        out_v_r <= 1'b1;
      end else if (out_tready) begin
        out_v_r <= 1'b0;
      end
      rd_v_r <= (state_r == S_SCAN || state_r == S_SUM) && !cnt_r[IDX_W];
      if ((state_r == S_SCAN || state_r == S_SUM) && !cnt_r[IDX_W]) begin
        rd_i_r <= cnt_r[IDX_W-1:0];
        cnt_r <= cnt_r + 1'b1;
      end
      unique case (state_r)
        S_IDLE: begin
          cnt_r <= '0;
          found_r <= 1'b0;
          bf_r <= 1'b0;
          af_r <= 1'b0;
          bt_r <= '0;
          at_r <= '0;
          if (in_tvalid) begin
            act_r <= in_tuser;
            id_r <= in_tdata[31:0];
            side_r <= in_tdata[32];
            price_r <= in_tdata[64:33];
            qty_r <= in_tdata[96:65];
            stamp_r <= arr_r;
            matched_r <= '0;
            status_r <= ST_DONE;
            if (in_tuser == ACT_ADD) arr_r <= arr_r + 32'd1;
          end
        end
        S_SCAN: begin
          if (cand && better) begin
            found_r <= 1'b1;
            fidx_r <= rd_i_r;
            fslot_r <= rslot;
          end
        end
        S_FILL: begin
          cnt_r <= '0;
          found_r <= 1'b0;
          if (act_r == ACT_ADD) begin
            if (found_r && crosses && qty_r != '0) begin
              qty_r <= qty_r - fill;
              matched_r <= matched_r + fill;
              if (fill == fslot_r.qty) valid_r[fidx_r] <= 1'b0;
            end else if (qty_r != '0) begin
              if (have_free) valid_r[free_idx] <= 1'b1;
              else status_r <= ST_FULL;
            end
          end else if (!found_r) begin
            status_r <= ST_NOTFOUND;
          end else if (kill) begin
            valid_r[fidx_r] <= 1'b0;
          end
        end
        S_SUM: begin
          if (rd_v_r && valid_r[rd_i_r]) begin
            if (!rslot.side) begin
              if (!bf_r || rslot.price > bp_r) begin
                bf_r <= 1'b1; bp_r <= rslot.price; bt_r <= addq_c;
              end else if (rslot.price == bp_r) begin
                bt_r <= sum_b[TOT_W] ? {TOT_W{1'b1}} : sum_b[TOT_W-1:0];
              end
            end else begin
              if (!af_r || rslot.price < ap_r) begin
                af_r <= 1'b1; ap_r <= rslot.price; at_r <= addq_c;
              end else if (rslot.price == ap_r) begin
                at_r <= sum_a[TOT_W] ? {TOT_W{1'b1}} : sum_a[TOT_W-1:0];
              end
            end
          end
        end
        S_OUT: begin
          if (!out_v_r || out_tready) begin
            out_r <= {4'd0, status_r, matched_r, at_r,
                      af_r ? {1'b0, ap_r} : {OUTP_W{1'b1}}, bt_r,
                      bf_r ? {1'b0, bp_r} : {OUTP_W{1'b1}}};
          end
        end
        default: ;
      endcase
    end
  end

  `LOBM_ASSERT(a_ready_idle, in_tready |-> (state_r == S_IDLE), "ready outside idle")
  `LOBM_ASSERT(a_out_hold, (out_tvalid && !out_tready) |=> out_tvalid, "result dropped")
  `LOBM_ASSERT(a_scan_bound, (state_r == S_SCAN) |-> (cnt_r <= (IDX_W+1)'(SLOTS)),
    "scan counter overrun")
endmodule
